@@ hw/rtl/lrsa_pkg.sv @@
// ----------------------------------------------------------------------------
// lrsa_pkg: shared definitions for the letter RSA modular exponentiator
// Field widths, configuration register indexes and character codes.
// ----------------------------------------------------------------------------
package lrsa_pkg;

  // Width of modulus, exponent and data words
  localparam int VAL_W = 34;
  // Counter width for one bit-serial multiply pass
  localparam int CNT_W = $clog2(VAL_W);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd2;

  // Mode codes
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Character and letter codes
  localparam logic [VAL_W-1:0] ASCII_A     = VAL_W'(65);
  localparam logic [VAL_W-1:0] ASCII_Z     = VAL_W'(90);
  localparam logic [VAL_W-1:0] ASCII_SPACE = VAL_W'(32);
  localparam logic [VAL_W-1:0] CODE_FIRST  = VAL_W'(2);
  localparam logic [VAL_W-1:0] CODE_LAST   = VAL_W'(27);
  localparam logic [VAL_W-1:0] CODE_SPACE  = VAL_W'(28);

  typedef logic [VAL_W-1:0] val_t;

endpackage

@@ hw/rtl/lrsa_ifs.sv @@
// ----------------------------------------------------------------------------
// lrsa_ifs: valid/ready channels of the letter RSA modular exponentiator
// Input channel carries one value; result channel carries value and flag.
// ----------------------------------------------------------------------------
interface lrsa_in_if;
  logic           valid;
  logic           ready;
  lrsa_pkg::val_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface lrsa_out_if;
  logic           valid;
  logic           ready;
  lrsa_pkg::val_t value;
  logic           invalid;

  modport source (output valid, output value, output invalid, input ready);
  modport sink   (input valid, input value, input invalid, output ready);
endinterface

@@ hw/rtl/letter_rsa_modexp.sv @@
// ----------------------------------------------------------------------------
// letter_rsa_modexp: one-letter RSA modular exponentiation
// Raises each word to the configured exponent modulo the configured modulus
// with one shared bit-serial modular multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake       Payload
//  in_word   in   valid/ready     value (34b): ASCII code or cipher value
//  out_word  out  valid/ready     value (34b), invalid (1b)
//  cfg_*     in   write enable    index (2b), wdata (34b): modulus/exponent/mode
//
//  Invalid characters in encrypt mode and a modulus <= 1 skip the
//  exponentiation and go straight to the finish state. The multiplier
//  resolves one multiplier bit per cycle.
//  rst_n is synchronous; it clears the sequencer, output valid and the config
//  registers (modulus 1, exponent 1, mode encrypt).
//  A finished result waits in the output register; the next word is accepted
//  meanwhile, and the sequencer holds at its end until the result is taken.
// ----------------------------------------------------------------------------
module letter_rsa_modexp (
  input  logic                              clk,
  input  logic                              rst_n,
  lrsa_in_if.sink                           in_word,
  lrsa_out_if.source                        out_word,
  input  logic                              cfg_we,
  input  logic [lrsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lrsa_pkg::VAL_W-1:0]        cfg_wdata
);

  localparam int W = lrsa_pkg::VAL_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MACC = 3'd3;
  localparam logic [2:0] S_MSQ  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  lrsa_pkg::val_t              modulus_r, exponent_r;
  logic                        mode_r;
  lrsa_pkg::val_t              acc_r, acc_nxt;
  lrsa_pkg::val_t              base_r, base_nxt;
  lrsa_pkg::val_t              exp_sh_r, exp_sh_nxt;
  logic                        bad_r, bad_nxt;
  lrsa_pkg::val_t              mm_r, mm_nxt;
  lrsa_pkg::val_t              mm_a_r, mm_a_nxt;
  lrsa_pkg::val_t              mm_b_r, mm_b_nxt;
  logic [lrsa_pkg::CNT_W-1:0]  mm_cnt_r, mm_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lrsa_pkg::val_t              out_value_r, out_value_nxt;
  logic                        out_invalid_r, out_invalid_nxt;

  lrsa_pkg::val_t              mm_dbl;
  lrsa_pkg::val_t              mm_step;
  logic                        mm_last;
  logic                        in_acc;
  logic                        out_free;
  logic                        mod_small;
  lrsa_pkg::val_t              code;
  logic                        code_ok;
  lrsa_pkg::val_t              map_value;
  logic                        map_bad;

  // (x + y) mod m for x, y < m
  function automatic lrsa_pkg::val_t add_mod(lrsa_pkg::val_t x, lrsa_pkg::val_t y,
                                             lrsa_pkg::val_t m);
    logic [W:0] s;
    logic [W:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, m};
    add_mod = (s >= {1'b0, m}) ? d[W-1:0] : s[W-1:0];
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= W'(1);
      exponent_r <= W'(1);
      mode_r     <= lrsa_pkg::MODE_ENCRYPT;
    end else if (cfg_we) begin
      case (cfg_index)
        lrsa_pkg::REG_MODULUS:  modulus_r  <= cfg_wdata;
        lrsa_pkg::REG_EXPONENT: exponent_r <= cfg_wdata;
        lrsa_pkg::REG_MODE:     mode_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Shared multiplier step: double, then add multiplicand on the next bit
  assign mm_dbl  = add_mod(mm_r, mm_r, modulus_r);
  assign mm_step = mm_b_r[W-1] ? add_mod(mm_dbl, mm_a_r, modulus_r) : mm_dbl;
  assign mm_last = (mm_cnt_r == lrsa_pkg::CNT_W'(W - 1));

  // Map the incoming character to its letter code
  always_comb begin
    code    = '0;
    code_ok = 1'b1;
    if (in_word.value >= lrsa_pkg::ASCII_A && in_word.value <= lrsa_pkg::ASCII_Z) begin
      code = in_word.value - lrsa_pkg::ASCII_A + lrsa_pkg::CODE_FIRST;
    end else if (in_word.value == lrsa_pkg::ASCII_SPACE) begin
      code = lrsa_pkg::CODE_SPACE;
    end else begin
      code_ok = 1'b0;
    end
  end

  // Map the modular result back to a character in decrypt mode; zero flagged words
  always_comb begin
    map_value = acc_r;
    map_bad   = 1'b0;
    if (mode_r == lrsa_pkg::MODE_DECRYPT) begin
      if (acc_r >= lrsa_pkg::CODE_FIRST && acc_r <= lrsa_pkg::CODE_LAST) begin
        map_value = acc_r - lrsa_pkg::CODE_FIRST + lrsa_pkg::ASCII_A;
      end else if (acc_r == lrsa_pkg::CODE_SPACE) begin
        map_value = lrsa_pkg::ASCII_SPACE;
      end else begin
        map_value = '0;
        map_bad   = 1'b1;
      end
    end
    if (bad_r) begin
      map_value = '0;
      map_bad   = 1'b1;
    end
  end

  assign in_word.ready    = (state_r == S_IDLE);
  assign in_acc           = in_word.valid && in_word.ready;
  assign out_free         = !out_valid_r || out_word.ready;
  assign mod_small        = (modulus_r <= W'(1));
  assign out_word.valid   = out_valid_r;
  assign out_word.value   = out_value_r;
  assign out_word.invalid = out_invalid_r;

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    acc_nxt         = acc_r;
    base_nxt        = base_r;
    exp_sh_nxt      = exp_sh_r;
    bad_nxt         = bad_r;
    mm_nxt          = mm_step;
    mm_a_nxt        = mm_a_r;
    mm_b_nxt        = {mm_b_r[W-2:0], 1'b0};
    mm_cnt_nxt      = mm_cnt_r + lrsa_pkg::CNT_W'(1);
    out_valid_nxt   = out_valid_r && !out_word.ready;
    out_value_nxt   = out_value_r;
    out_invalid_nxt = out_invalid_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          acc_nxt    = W'(1);
          exp_sh_nxt = exponent_r;
          bad_nxt    = 1'b0;
          mm_nxt     = '0;
          mm_a_nxt   = W'(1);
          mm_cnt_nxt = '0;
          mm_b_nxt   = (mode_r == lrsa_pkg::MODE_ENCRYPT) ? code : in_word.value;
          if (mode_r == lrsa_pkg::MODE_ENCRYPT && !code_ok) begin
            bad_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else if (mod_small) begin
            acc_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        // reduce the base: 1 * value mod m
        if (mm_last) begin
          base_nxt  = mm_step;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        mm_nxt     = '0;
        mm_cnt_nxt = '0;
        if (exp_sh_r == '0) begin
          state_nxt = S_FIN;
        end else if (exp_sh_r[0]) begin
          mm_a_nxt  = acc_r;
          mm_b_nxt  = base_r;
          state_nxt = S_MACC;
        end else begin
          mm_a_nxt  = base_r;
          mm_b_nxt  = base_r;
          state_nxt = S_MSQ;
        end
      end
      S_MACC: begin
        if (mm_last) begin
          acc_nxt    = mm_step;
          mm_nxt     = '0;
          mm_cnt_nxt = '0;
          mm_a_nxt   = base_r;
          mm_b_nxt   = base_r;
          state_nxt  = S_MSQ;
        end
      end
      S_MSQ: begin
        if (mm_last) begin
          base_nxt   = mm_step;
          exp_sh_nxt = {1'b0, exp_sh_r[W-1:1]};
          state_nxt  = S_CHK;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_value_nxt   = map_value;
          out_invalid_nxt = map_bad;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    acc_r         <= acc_nxt;
    base_r        <= base_nxt;
    exp_sh_r      <= exp_sh_nxt;
    bad_r         <= bad_nxt;
    mm_r          <= mm_nxt;
    mm_a_r        <= mm_a_nxt;
    mm_b_r        <= mm_b_nxt;
    mm_cnt_r      <= mm_cnt_nxt;
    out_value_r   <= out_value_nxt;
    out_invalid_r <= out_invalid_nxt;
  end

endmodule

@@ hw/rtl/lrsa_checker.sv @@
// ----------------------------------------------------------------------------
// lrsa_checker: port-level checks for the letter RSA modular exponentiator
// Watches the word channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lrsa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lrsa_pkg::VAL_W-1:0]  out_value,
  input logic                        out_invalid
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_invalid))
    else $error("stalled result word changed");

  // Flagged words carry a zero value
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_value == '0)
    else $error("invalid word with nonzero value");

  // Drop ready for the work after an accepted word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after accept");

  // Clear the result channel and raise input ready on reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result valid or not ready after reset");

endmodule

bind letter_rsa_modexp lrsa_checker u_lrsa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_word.valid),
  .in_ready    (in_word.ready),
  .out_valid   (out_word.valid),
  .out_ready   (out_word.ready),
  .out_value   (out_word.value),
  .out_invalid (out_word.invalid)
);
